>>> sv/aes256_counter_mode_stream_macros.svh
// Assertion helpers for the AES-256 counter mode stream block.
`ifndef AES256_COUNTER_MODE_STREAM_MACROS_SVH
`define AES256_COUNTER_MODE_STREAM_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ACTR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ACTR_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/aesctr_pkg.sv
// ----------------------------------------------------------------------------
// aesctr_pkg
// Shared types, constants and AES round functions for the CTR stream block.
// ----------------------------------------------------------------------------
`default_nettype none

package aesctr_pkg;

  localparam int LANES       = 4;
  localparam int BLOCK_BYTES = 16;
  localparam int ROUNDS      = 14;
  localparam int NUM_REGS    = 6;

  typedef enum logic [2:0] {
    REG_KEY0    = 3'd0,
    REG_KEY1    = 3'd1,
    REG_KEY2    = 3'd2,
    REG_KEY3    = 3'd3,
    REG_IV_HIGH = 3'd4,
    REG_IV_LOW  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

  typedef struct packed {
    logic [127:0] ks;
    logic [127:0] data;
    logic [4:0]   count;
    logic         last;
  } lane_res_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // One cipher round: SubBytes, ShiftRows, MixColumns unless last.
  // Byte 0 of the state sits in bits 127:120.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last_rnd);
    logic [7:0]   b [16];
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, all;
    logic [127:0] r;
    for (int k = 0; k < 16; k++) begin
      b[k] = s[127-8*k -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i+4*c] = sbox(b[i+4*((c+i)&3)]);
      end
    end
    if (!last_rnd) begin
      for (int c = 0; c < 4; c++) begin
        a0  = t[4*c];
        a1  = t[4*c+1];
        a2  = t[4*c+2];
        a3  = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int k = 0; k < 16; k++) begin
      r[127-8*k -: 8] = t[k];
    end
    return r;
  endfunction

  // Next four key-schedule words from the last eight (oldest in top bits).
  function automatic logic [127:0] key_step(input logic [255:0] w, input logic odd,
                                            input logic [7:0] rc);
    logic [31:0] prev, t, n0, n1, n2, n3;
    prev = w[31:0];
    if (odd) begin
      t = sub_word({prev[23:0], prev[31:24]}) ^ {rc, 24'h0};
    end else begin
      t = sub_word(prev);
    end
    n0 = w[255:224] ^ t;
    n1 = w[223:192] ^ n0;
    n2 = w[191:160] ^ n1;
    n3 = w[159:128] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

`default_nettype wire

>>> sv/aesctr_lane.sv
// ----------------------------------------------------------------------------
// aesctr_lane
// Iterative AES-256 lane: one round per cycle, key schedule on the fly.
// ----------------------------------------------------------------------------
`default_nettype none

module aesctr_lane
  import aesctr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic         pop,
  input  wire logic [255:0] key,
  input  wire logic [127:0] ctr,
  input  wire logic [127:0] data,
  input  wire logic [4:0]   count,
  input  wire logic         last,
  output lane_stat_t        stat,
  output lane_res_t         res
);

  logic         busy;
  logic         running;
  logic [3:0]   rnd;
  logic [127:0] st;
  logic [255:0] win;
  logic [127:0] dat;
  logic [4:0]   cnt;
  logic         lst;
  logic [7:0]   rc;

  // rcon for odd rounds: 01, 02, 04, ...
  assign rc = 8'h01 << ((rnd - 4'd1) >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      running <= 1'b0;
      rnd     <= 4'd0;
    end else begin
      if (start) begin
        busy    <= 1'b1;
        running <= 1'b1;
        rnd     <= 4'd1;
      end else if (running) begin
        rnd <= rnd + 4'd1;
        if (rnd == 4'(ROUNDS)) begin
          running <= 1'b0;
        end
      end else if (pop) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      st  <= ctr ^ key[255:128];
      win <= key;
      dat <= data;
      cnt <= count;
      lst <= last;
    end else if (running) begin
      st  <= aes_round(st, rnd == 4'(ROUNDS)) ^ win[127:0];
      win <= {win[127:0], key_step(win, rnd[0], rc)};
    end
  end

  assign stat.busy = busy;
  assign stat.done = busy & ~running;
  assign res.ks    = st;
  assign res.data  = dat;
  assign res.count = cnt;
  assign res.last  = lst;

endmodule

`default_nettype wire

>>> sv/aes256_counter_mode_stream.sv
// Each accepted item runs its lane's 14 rounds, one round per cycle, then
// waits until the merge takes it into the output register. A lane takes no
// new item before its last one is popped; NumLanes lanes hold NumLanes items.
// Items leave in arrival order through a single output register.
// Reset: synchronous; clears config registers, counter, lanes and output valid.
// ----------------------------------------------------------------------------
// aes256_counter_mode_stream
// AES-256-CTR stream: round-robin dispatch to lanes, in-order merge.
// ----------------------------------------------------------------------------
`default_nettype none

module aes256_counter_mode_stream
  import aesctr_pkg::*;
#(
  parameter int NumLanes = LANES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] data_high,
  input  wire logic [63:0] data_low,
  input  wire logic [4:0]  byte_count,
  input  wire logic        first_block,
  input  wire logic        last_block,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [63:0] out_high,
  output logic      [63:0] out_low,
  output logic      [4:0]  valid_bytes,
  output logic             last_out
);

  `include "aes256_counter_mode_stream_macros.svh"

  localparam int PtrW = (NumLanes > 1) ? $clog2(NumLanes) : 1;

  logic [63:0]     cfg_reg [NUM_REGS];
  logic [127:0]    ctr;
  logic [127:0]    ctr_use;
  logic [4:0]      cnt_in;
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic            in_acc;
  logic            take;
  logic [2:0]      reg_sel;
  logic [NumLanes-1:0] lane_busy;
  logic [NumLanes-1:0] lane_done;
  logic [NumLanes-1:0] lane_start;
  logic [NumLanes-1:0] lane_pop;
  lane_stat_t      stat_vec [NumLanes];
  lane_res_t       res_vec  [NumLanes];
  lane_res_t       sel;
  logic [127:0]    merged;

  // Config port
  assign pready  = 1'b1;
  assign reg_sel = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_reg[i] <= 64'h0;
      end
    end else if (psel && penable && pwrite && reg_sel < 3'(NUM_REGS)) begin
      cfg_reg[reg_sel] <= pwdata;
    end
  end

  always_comb begin
    prdata = (reg_sel < 3'(NUM_REGS)) ? cfg_reg[reg_sel] : 64'h0;
  end

  // Dispatch
  assign in_ready = ~lane_busy[wr_ptr];
  assign in_acc   = in_valid & in_ready;
  assign ctr_use  = first_block ? {cfg_reg[REG_IV_HIGH], cfg_reg[REG_IV_LOW]} : ctr;
  assign cnt_in   = (byte_count > 5'(BLOCK_BYTES)) ? 5'(BLOCK_BYTES) : byte_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr    <= 128'h0;
      wr_ptr <= '0;
    end else if (in_acc) begin
      ctr    <= ctr_use + 128'h1;
      wr_ptr <= (wr_ptr == PtrW'(NumLanes - 1)) ? '0 : wr_ptr + PtrW'(1);
    end
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    assign lane_start[g] = in_acc && (wr_ptr == PtrW'(g));
    assign lane_pop[g]   = take && (rd_ptr == PtrW'(g));
    assign lane_busy[g]  = stat_vec[g].busy;
    assign lane_done[g]  = stat_vec[g].done;

    aesctr_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .start (lane_start[g]),
      .pop   (lane_pop[g]),
      .key   ({cfg_reg[REG_KEY0], cfg_reg[REG_KEY1], cfg_reg[REG_KEY2], cfg_reg[REG_KEY3]}),
      .ctr   (ctr_use),
      .data  ({data_high, data_low}),
      .count (cnt_in),
      .last  (last_block),
      .stat  (stat_vec[g]),
      .res   (res_vec[g])
    );
  end

  // Merge: oldest lane into the output register
  assign sel  = res_vec[rd_ptr];
  assign take = lane_done[rd_ptr] & (~out_valid | out_ready);

  always_comb begin
    merged = sel.data ^ sel.ks;
    for (int k = 0; k < BLOCK_BYTES; k++) begin
      if (5'(k) >= sel.count) begin
        merged[127-8*k -: 8] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rd_ptr    <= '0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        rd_ptr    <= (rd_ptr == PtrW'(NumLanes - 1)) ? '0 : rd_ptr + PtrW'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_high    <= merged[127:64];
      out_low     <= merged[63:0];
      valid_bytes <= sel.count;
      last_out    <= sel.last;
    end
  end

  `ACTR_ASSERT_IMP(a_pop_done, clk, rst, |lane_pop, lane_done[rd_ptr])
  `ACTR_ASSERT_IMP(a_oldest_busy, clk, rst, |lane_busy, lane_busy[rd_ptr])
  `ACTR_ASSERT_NXT(a_start_busy, clk, rst, in_acc, lane_busy[$past(wr_ptr)])

endmodule

`default_nettype wire
